/* rtl/core/led_ring_pattern_generator_assert.svh */
// assertion macros for the led ring pattern generator
// the enclosing module provides clk_i and rst_ni
`ifndef LED_RING_PATTERN_GENERATOR_ASSERT_SVH
`define LED_RING_PATTERN_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LRPG_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define LRPG_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define LRPG_ASSERT(name, prop)
`define LRPG_ASSERT_ALWAYS(name, prop)
`endif
`endif

/* rtl/core/lrpg_pkg.sv */
package lrpg_pkg;

  localparam int unsigned RING_SIZE = 16;
  localparam int unsigned LED_W     = 4;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned SECTOR    = 65536 / RING_SIZE;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // pipeline: input register, six reduction stages, two color stages
  localparam int unsigned REDUCE_STAGES = 6;
  localparam int unsigned COLOR_STAGES  = 2;
  localparam int unsigned NUM_STAGES    = 1 + REDUCE_STAGES + COLOR_STAGES;

  // time mod 20 s: low byte passes through, the rest is reduced mod 5^7
  localparam int unsigned TIME_LO_W   = 8;
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned CHUNK_COUNT = 7;
  localparam int unsigned HI_PROD_W   = 25;
  localparam int unsigned PAIR_W      = 26;
  localparam int unsigned SUM_W       = 28;
  localparam int unsigned QHI_W       = 12;
  localparam int unsigned REM_W       = 17;
  localparam int unsigned S20_W       = 25;
  localparam int unsigned S1_W        = 20;
  localparam int unsigned CSTEP_W     = 5;
  localparam int unsigned TP_W        = 16;

  localparam logic [REM_W-1:0] MOD_HI = 17'd78125;
  localparam logic [QHI_W-1:0] MOD_HI_RECIP = 12'd3435;
  localparam int unsigned MOD_HI_SHIFT = 28;

  // 256^i mod 78125
  localparam logic [REM_W-1:0] CHUNK_WEIGHT [CHUNK_COUNT] = '{
    17'd1, 17'd256, 17'd65536, 17'd58466, 17'd45421, 17'd65276, 17'd70031
  };

  localparam logic [5:0] SEC_RECIP = 6'd33;
  localparam int unsigned SEC_SHIFT = 19;
  localparam int unsigned SECOND_US = 1000000;

  // ceil(2^50 / 1e6), exact floor for s1 * 65536 / 1e6
  localparam logic [30:0] TP_RECIP = 31'd1125899907;
  localparam int unsigned TP_SHIFT = 34;

  localparam int unsigned STROBE_ON  = 50000;
  localparam int unsigned STROBE_GAP = 250000;
  localparam int unsigned STROBE_OFF = 300000;

  localparam int unsigned POLICE_STEPS = 12;
  localparam logic [COLOR_W-1:0] DIM  = 8'd50;
  localparam logic [COLOR_W-1:0] FULL = 8'd255;

  localparam logic [POS_W-1:0] THIRD_TURN     = 16'd21845;
  localparam logic [POS_W-1:0] TWO_THIRD_TURN = 16'd43691;

  localparam int unsigned SINE_BASE = 12;
  localparam logic [8:0] RISE_AT [12] = '{
    9'd7, 9'd20, 9'd33, 9'd47, 9'd61, 9'd75, 9'd90, 9'd105, 9'd122, 9'd141, 9'd163, 9'd191
  };

  typedef enum logic [3:0] {
    MODE_OFF          = 4'd0,
    MODE_COMMANDED    = 4'd1,
    MODE_RED_GREEN    = 4'd2,
    MODE_RED          = 4'd3,
    MODE_GREEN        = 4'd4,
    MODE_RAINBOW      = 4'd5,
    MODE_POLICE       = 4'd6,
    MODE_POLICE_LEFT  = 4'd7,
    MODE_POLICE_RIGHT = 4'd8,
    MODE_CHASE        = 4'd9,
    MODE_HEADING      = 4'd10
  } lrpg_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_MODE    = 3'd0,
    CFG_STROBE_ENABLE   = 3'd1,
    CFG_ANGLE_OFFSET    = 3'd2,
    CFG_COMMANDED_RED   = 3'd3,
    CFG_COMMANDED_GREEN = 3'd4,
    CFG_COMMANDED_BLUE  = 3'd5
  } lrpg_cfg_idx_e;

  typedef struct packed {
    logic [3:0]       pattern_mode;
    logic             strobe_enable;
    logic [POS_W-1:0] angle_offset;
    logic [4:0]       commanded_red;
    logic [5:0]       commanded_green;
    logic [4:0]       commanded_blue;
  } lrpg_cfg_t;

  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [S1_W-1:0]    s1;
    logic [CSTEP_W-1:0] cstep;
  } lrpg_phase_t;

  // floor(12.5 * (1 + sin(2 pi idx / 1024)))
  function automatic logic [4:0] sine_rom(input logic [9:0] idx);
    logic [8:0] k;
    logic [8:0] q;
    logic [4:0] n;
    k = idx[8:0];
    q = (k > 9'd256) ? 9'(10'd512 - {1'b0, k}) : k;
    n = '0;
    for (int m = 0; m < 12; m++) begin
      if (q >= RISE_AT[m]) begin
        n = n + 5'd1;
      end
    end
    if (!idx[9]) begin
      return 5'(SINE_BASE) + n + {4'd0, q == 9'd256};
    end
    return 5'(SINE_BASE) - n;
  endfunction

  // floor(12 * s1 / 1e6)
  function automatic logic [3:0] police_step(input logic [S1_W-1:0] s1);
    logic [23:0] scaled;
    logic [3:0]  n;
    scaled = 24'(s1) * 24'(POLICE_STEPS);
    n = '0;
    for (int k = 1; k < POLICE_STEPS; k++) begin
      if (scaled >= 24'(k * SECOND_US)) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/core/lrpg_time_reduce.sv */
module lrpg_time_reduce (
  input  logic                                     clk_i,
  input  logic [lrpg_pkg::REDUCE_STAGES-1:0]       en_i,
  input  logic [lrpg_pkg::LED_W-1:0]               led_i,
  input  logic [lrpg_pkg::TIME_W-1:0]              time_i,
  output lrpg_pkg::lrpg_phase_t                    phase_o
);
  import lrpg_pkg::*;

  // stage 1: residue of each byte of time >> 8, summed in pairs
  logic [HI_PROD_W-1:0] prod [CHUNK_COUNT];
  logic [PAIR_W-1:0]    pair_d [4];
  logic [PAIR_W-1:0]    pair_q [4];
  logic [LED_W-1:0]     led1_q;
  logic [TIME_LO_W-1:0] lo1_q;

  always_comb begin
    for (int i = 0; i < CHUNK_COUNT; i++) begin
      prod[i] = HI_PROD_W'(time_i[TIME_LO_W + i * CHUNK_W +: CHUNK_W])
              * HI_PROD_W'(CHUNK_WEIGHT[i]);
    end
    pair_d[0] = PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
    pair_d[1] = PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    pair_d[2] = PAIR_W'(prod[4]) + PAIR_W'(prod[5]);
    pair_d[3] = PAIR_W'(prod[6]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pair_q <= pair_d;
      led1_q <= led_i;
      lo1_q  <= time_i[TIME_LO_W-1:0];
    end
  end

  // stage 2: total residue sum
  logic [SUM_W-1:0]     sum2_d;
  logic [SUM_W-1:0]     sum2_q;
  logic [LED_W-1:0]     led2_q;
  logic [TIME_LO_W-1:0] lo2_q;

  assign sum2_d = SUM_W'(pair_q[0]) + SUM_W'(pair_q[1])
                + SUM_W'(pair_q[2]) + SUM_W'(pair_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sum2_q <= sum2_d;
      led2_q <= led1_q;
      lo2_q  <= lo1_q;
    end
  end

  // stage 3: quotient estimate, low by at most one
  logic [SUM_W+QHI_W-1:0] recip_prod;
  logic [QHI_W-1:0]       qe3_d;
  logic [QHI_W-1:0]       qe3_q;
  logic [SUM_W-1:0]       sum3_q;
  logic [LED_W-1:0]       led3_q;
  logic [TIME_LO_W-1:0]   lo3_q;

  assign recip_prod = (SUM_W + QHI_W)'(sum2_q) * (SUM_W + QHI_W)'(MOD_HI_RECIP);
  assign qe3_d      = recip_prod[MOD_HI_SHIFT +: QHI_W];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qe3_q  <= qe3_d;
      sum3_q <= sum2_q;
      led3_q <= led2_q;
      lo3_q  <= lo2_q;
    end
  end

  // stage 4: remainder with one correction, time mod 20 s
  logic [SUM_W-1:0]   rem_full;
  logic [REM_W:0]     rem_raw;
  logic [REM_W-1:0]   rem_fix;
  logic [S20_W-1:0]   s20_4_q;
  logic [LED_W-1:0]   led4_q;

  always_comb begin
    rem_full = sum3_q - SUM_W'(qe3_q) * SUM_W'(MOD_HI);
    rem_raw  = rem_full[REM_W:0];
    if (rem_raw >= {1'b0, MOD_HI}) begin
      rem_fix = REM_W'(rem_raw - {1'b0, MOD_HI});
    end else begin
      rem_fix = rem_raw[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s20_4_q <= {rem_fix, lo3_q};
      led4_q  <= led3_q;
    end
  end

  // stage 5: whole seconds estimate
  logic [S20_W-1:0]   sec_prod;
  logic [CSTEP_W-1:0] q5_q;
  logic [S20_W-1:0]   s20_5_q;
  logic [LED_W-1:0]   led5_q;

  assign sec_prod = S20_W'(s20_4_q[S20_W-1:6]) * S20_W'(SEC_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      q5_q    <= sec_prod[SEC_SHIFT +: CSTEP_W];
      s20_5_q <= s20_4_q;
      led5_q  <= led4_q;
    end
  end

  // stage 6: microseconds within the second and second count
  logic [S20_W-1:0]  r6;
  lrpg_phase_t       phase_d;
  lrpg_phase_t       phase_q;

  always_comb begin
    r6 = s20_5_q - S20_W'(q5_q) * S20_W'(SECOND_US);
    phase_d.led = led5_q;
    if (r6 >= S20_W'(SECOND_US)) begin
      phase_d.s1    = S1_W'(r6 - S20_W'(SECOND_US));
      phase_d.cstep = q5_q + CSTEP_W'(1);
    end else begin
      phase_d.s1    = r6[S1_W-1:0];
      phase_d.cstep = q5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

/* rtl/core/lrpg_color.sv */
module lrpg_color (
  input  logic                               clk_i,
  input  logic [lrpg_pkg::COLOR_STAGES-1:0]  en_i,
  input  lrpg_pkg::lrpg_cfg_t                cfg_i,
  input  lrpg_pkg::lrpg_phase_t              phase_i,
  output logic [lrpg_pkg::COLOR_W-1:0]       red_o,
  output logic [lrpg_pkg::COLOR_W-1:0]       green_o,
  output logic [lrpg_pkg::COLOR_W-1:0]       blue_o
);
  import lrpg_pkg::*;

  // stage 7: led angle, strobe window, police phase, chase match, rainbow phase
  logic [POS_W-1:0]         pos_d;
  logic [S1_W:0]            s2;
  logic [3:0]               pstep;
  logic [S1_W+30:0]         tp_prod;
  logic                     flash_d;
  logic                     phase_a_d;
  logic                     phase_b_d;
  logic                     chase_d;

  logic [POS_W-1:0]         pos_q;
  logic [TP_W-1:0]          tp_q;
  logic                     flash_q;
  logic                     phase_a_q;
  logic                     phase_b_q;
  logic                     chase_q;

  always_comb begin
    pos_d = POS_W'(int'(phase_i.led) * SECTOR + SECTOR / 2) - cfg_i.angle_offset;
    // position within the 2 s strobe period
    s2 = (S1_W + 1)'(phase_i.s1)
       + (phase_i.cstep[0] ? (S1_W + 1)'(SECOND_US) : '0);
    flash_d = cfg_i.strobe_enable
           && ((s2 < (S1_W + 1)'(STROBE_ON))
           || ((s2 > (S1_W + 1)'(STROBE_GAP)) && (s2 < (S1_W + 1)'(STROBE_OFF))));
    pstep = police_step(phase_i.s1);
    phase_a_d = (pstep == 4'd0) || (pstep == 4'd2) || (pstep == 4'd4);
    phase_b_d = (pstep == 4'd6) || (pstep == 4'd8) || (pstep == 4'd10);
    chase_d = (CSTEP_W'(phase_i.led) == phase_i.cstep);
    tp_prod = (S1_W + 31)'(phase_i.s1) * (S1_W + 31)'(TP_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pos_q     <= pos_d;
      tp_q      <= tp_prod[TP_SHIFT +: TP_W];
      flash_q   <= flash_d;
      phase_a_q <= phase_a_d;
      phase_b_q <= phase_b_d;
      chase_q   <= chase_d;
    end
  end

  // stage 8: pattern select
  logic [POS_W-1:0]   ang_r;
  logic [POS_W-1:0]   ang_g;
  logic [POS_W-1:0]   ang_b;
  logic               left;
  logic               use_left;
  lrpg_mode_e         mode;
  logic [COLOR_W-1:0] red_d;
  logic [COLOR_W-1:0] green_d;
  logic [COLOR_W-1:0] blue_d;

  always_comb begin
    ang_r    = tp_q + pos_q;
    ang_g    = ang_r + THIRD_TURN;
    ang_b    = ang_r + TWO_THIRD_TURN;
    left     = !pos_q[POS_W-1];
    mode     = lrpg_mode_e'(cfg_i.pattern_mode);
    use_left = (mode == MODE_POLICE_RIGHT) || ((mode == MODE_POLICE) && left);
    red_d    = '0;
    green_d  = '0;
    blue_d   = '0;
    case (mode)
      MODE_COMMANDED: begin
        red_d   = {cfg_i.commanded_red, 3'b000};
        green_d = {cfg_i.commanded_green, 2'b00};
        blue_d  = {cfg_i.commanded_blue, 3'b000};
      end
      MODE_RED_GREEN: begin
        if (flash_q) begin
          {red_d, green_d, blue_d} = {FULL, FULL, FULL};
        end else if (left) begin
          green_d = DIM;
        end else begin
          red_d = DIM;
        end
      end
      MODE_RED: begin
        if (flash_q) begin
          {red_d, green_d, blue_d} = {FULL, FULL, FULL};
        end else begin
          red_d = DIM;
        end
      end
      MODE_GREEN: begin
        if (flash_q) begin
          {red_d, green_d, blue_d} = {FULL, FULL, FULL};
        end else begin
          green_d = DIM;
        end
      end
      MODE_RAINBOW: begin
        red_d   = COLOR_W'(sine_rom(ang_r[POS_W-1:6]));
        green_d = COLOR_W'(sine_rom(ang_g[POS_W-1:6]));
        blue_d  = COLOR_W'(sine_rom(ang_b[POS_W-1:6]));
      end
      MODE_POLICE, MODE_POLICE_LEFT, MODE_POLICE_RIGHT: begin
        if (use_left) begin
          if (phase_a_q) begin
            blue_d = FULL;
          end else if (phase_b_q) begin
            {red_d, green_d, blue_d} = {FULL, FULL, FULL};
          end
        end else begin
          if (phase_a_q) begin
            {red_d, green_d, blue_d} = {FULL, FULL, FULL};
          end else if (phase_b_q) begin
            red_d = FULL;
          end
        end
      end
      MODE_CHASE: begin
        if (chase_q) begin
          {red_d, green_d, blue_d} = {FULL, FULL, FULL};
        end
      end
      MODE_HEADING: begin
        {red_d, green_d, blue_d} = '0;
      end
      default: begin
        // off, and the unused codes above heading
        if (flash_q) begin
          {red_d, green_d, blue_d} = {FULL, FULL, FULL};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      red_o   <= red_d;
      green_o <= green_d;
      blue_o  <= blue_d;
    end
  end

endmodule

/* rtl/core/led_ring_pattern_generator.sv */
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o   | led_position_i, time_us_i
// out     | output    | out_valid_o / out_ready_i | red_o, green_o, blue_o
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while the output is not stalled; each result passes the input register,
// the mod 20 s reduction of the timestamp (six stages) and two color stages
// each stage loads whenever it is empty or its successor moves, so bubbles close up
// while a result waits at the output register
// reset empties the pipeline and loads the register reset values (rainbow mode)
`include "led_ring_pattern_generator_assert.svh"

module led_ring_pattern_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lrpg_pkg::LED_W-1:0]        led_position_i,
  input  logic [lrpg_pkg::TIME_W-1:0]       time_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lrpg_pkg::COLOR_W-1:0]      red_o,
  output logic [lrpg_pkg::COLOR_W-1:0]      green_o,
  output logic [lrpg_pkg::COLOR_W-1:0]      blue_o,
  input  logic                              cfg_we_i,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lrpg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lrpg_pkg::*;

  localparam int unsigned STAGE_LAST = NUM_STAGES - 1;

  // configuration registers
  lrpg_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_mode    <= MODE_RAINBOW;
      cfg_q.strobe_enable   <= 1'b0;
      cfg_q.angle_offset    <= '0;
      cfg_q.commanded_red   <= '0;
      cfg_q.commanded_green <= '0;
      cfg_q.commanded_blue  <= '0;
    end else if (cfg_we_i) begin
      case (lrpg_cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_MODE:    cfg_q.pattern_mode    <= cfg_wdata_i[3:0];
        CFG_STROBE_ENABLE:   cfg_q.strobe_enable   <= cfg_wdata_i[0];
        CFG_ANGLE_OFFSET:    cfg_q.angle_offset    <= cfg_wdata_i[POS_W-1:0];
        CFG_COMMANDED_RED:   cfg_q.commanded_red   <= cfg_wdata_i[4:0];
        CFG_COMMANDED_GREEN: cfg_q.commanded_green <= cfg_wdata_i[5:0];
        CFG_COMMANDED_BLUE:  cfg_q.commanded_blue  <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy and per-stage load enables
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[STAGE_LAST] = !valid_q[STAGE_LAST] || out_ready_i;
    for (int k = STAGE_LAST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGE_LAST];

  // input register
  logic [LED_W-1:0]  led_q;
  logic [TIME_W-1:0] time_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      led_q  <= led_position_i;
      time_q <= time_us_i;
    end
  end

  lrpg_phase_t phase;

  lrpg_time_reduce u_time_reduce (
    .clk_i   (clk_i),
    .en_i    (en[REDUCE_STAGES:1]),
    .led_i   (led_q),
    .time_i  (time_q),
    .phase_o (phase)
  );

  lrpg_color u_color (
    .clk_i   (clk_i),
    .en_i    (en[STAGE_LAST:REDUCE_STAGES+1]),
    .cfg_i   (cfg_q),
    .phase_i (phase),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  `LRPG_ASSERT(a_ready_when_drained, !out_valid_o |-> in_ready_o)
  `LRPG_ASSERT(a_accept_loads_input, (in_valid_i && in_ready_o) |=> valid_q[0])
  `LRPG_ASSERT(a_tail_holds, (&valid_q[STAGE_LAST-:2] && !out_ready_i) |=> &valid_q[STAGE_LAST-:2])

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lrpg_pkg::*;

  localparam int unsigned HOLD_LEN       = 200;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned RANDOM_PHASES  = 16;
  localparam int unsigned PHASE_ITEMS    = 36;
  localparam int unsigned PRESSURE_ITEMS = 40;
  localparam int unsigned STROBE_PERIOD  = 2 * SECOND_US;
  localparam int unsigned CHASE_PERIOD   = 20 * SECOND_US;
  localparam real         TWO_PI         = 6.283185307179586;

  // register indexes past the last register, and mode codes past heading
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;
  localparam logic [3:0]           MODE_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [LED_W-1:0]      led_position_i;
  logic [TIME_W-1:0]     time_us_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [COLOR_W-1:0]    red_o;
  logic [COLOR_W-1:0]    green_o;
  logic [COLOR_W-1:0]    blue_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // shadow copy of the register file, reset values
  logic [3:0]       cfg_mode   = 4'(MODE_RAINBOW);
  logic             cfg_strobe = 1'b0;
  logic [POS_W-1:0] cfg_offset = '0;
  logic [4:0]       cfg_red    = '0;
  logic [5:0]       cfg_green  = '0;
  logic [4:0]       cfg_blue   = '0;

  logic [COLOR_W-1:0] sine_lut [1024];
  color_t expected_colors [$];

  int err_count     = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_taken   = 0;
  int quiet_cycles  = 0;

  led_ring_pattern_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .led_position_i (led_position_i),
    .time_us_i      (time_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic color_t paint_led(input logic [LED_W-1:0] led, input logic [63:0] t);
    logic [POS_W-1:0] angle;
    logic [POS_W-1:0] hue;
    logic [POS_W-1:0] hue_g;
    logic [POS_W-1:0] hue_b;
    logic [63:0]      s1;
    logic [63:0]      s2;
    logic [63:0]      s20;
    logic [63:0]      pstep;
    logic             left_half;
    logic             flashing;
    logic             blue_phase;
    logic             red_phase;
    logic             left_rule;
    lrpg_mode_e       mode;
    color_t           c;
    // centre of the LED's sector, turned back by the offset
    angle = 16'(led * SECTOR + SECTOR / 2) - cfg_offset;
    left_half = angle < 16'h8000;
    s1 = t % SECOND_US;
    s2 = t % STROBE_PERIOD;
    s20 = t % CHASE_PERIOD;
    mode = (cfg_mode > MODE_HEADING) ? MODE_OFF : lrpg_mode_e'(cfg_mode);
    flashing = cfg_strobe && (s2 < STROBE_ON || (s2 > STROBE_GAP && s2 < STROBE_OFF));
    pstep = s1 * POLICE_STEPS / SECOND_US;
    blue_phase = !pstep[0] && pstep < 6;
    red_phase = !pstep[0] && pstep >= 6;
    c = '{8'd0, 8'd0, 8'd0};
    if (flashing && (mode == MODE_OFF || mode == MODE_RED_GREEN || mode == MODE_RED ||
                     mode == MODE_GREEN)) begin
      c = '{FULL, FULL, FULL};
    end else begin
      case (mode)
        MODE_COMMANDED: c = '{{cfg_red, 3'b0}, {cfg_green, 2'b0}, {cfg_blue, 3'b0}};
        MODE_RED_GREEN: begin
          if (left_half) c = '{8'd0, DIM, 8'd0};
          else c = '{DIM, 8'd0, 8'd0};
        end
        MODE_RED:   c = '{DIM, 8'd0, 8'd0};
        MODE_GREEN: c = '{8'd0, DIM, 8'd0};
        MODE_RAINBOW: begin
          hue = 16'(s1 * 65536 / SECOND_US) + angle;
          hue_g = hue + THIRD_TURN;
          hue_b = hue + TWO_THIRD_TURN;
          c = '{sine_lut[hue[15:6]], sine_lut[hue_g[15:6]], sine_lut[hue_b[15:6]]};
        end
        MODE_POLICE, MODE_POLICE_LEFT, MODE_POLICE_RIGHT: begin
          left_rule = (mode == MODE_POLICE_RIGHT) || (mode == MODE_POLICE && left_half);
          if (blue_phase) begin
            if (left_rule) c = '{8'd0, 8'd0, FULL};
            else c = '{FULL, FULL, FULL};
          end else if (red_phase) begin
            if (left_rule) c = '{FULL, FULL, FULL};
            else c = '{FULL, 8'd0, 8'd0};
          end
        end
        MODE_CHASE: begin
          if (64'(led) == s20 / SECOND_US) c = '{FULL, FULL, FULL};
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // random timestamps, some of them close to a strobe or police boundary of the patterns
  function automatic logic [63:0] pick_time(input logic [LED_W-1:0] led);
    logic [63:0] base;
    logic [63:0] mark;
    base = 64'($urandom);
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, CHASE_PERIOD - 1));
      2: begin
        case ($urandom_range(0, 3))
          0: mark = 64'd0;
          1: mark = 64'(STROBE_ON);
          2: mark = 64'(STROBE_GAP);
          default: mark = 64'(STROBE_OFF);
        endcase
        return base * STROBE_PERIOD + mark + 64'($urandom_range(0, 4)) - 64'd2;
      end
      3: begin
        mark = 64'(($urandom_range(1, POLICE_STEPS - 1) * SECOND_US + POLICE_STEPS - 1)
                   / POLICE_STEPS);
        return base * SECOND_US + mark + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: return base * CHASE_PERIOD + 64'(led) * SECOND_US +
                      64'($urandom_range(0, SECOND_US - 1));
    endcase
  endfunction

  task automatic offer_pixel(input logic [LED_W-1:0] led, input logic [63:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    led_position_i <= led;
    time_us_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    expected_colors.push_back(paint_led(led, t));
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PATTERN_MODE:    cfg_mode = data[3:0];
      CFG_STROBE_ENABLE:   cfg_strobe = data[0];
      CFG_ANGLE_OFFSET:    cfg_offset = data;
      CFG_COMMANDED_RED:   cfg_red = data[4:0];
      CFG_COMMANDED_GREEN: cfg_green = data[5:0];
      CFG_COMMANDED_BLUE:  cfg_blue = data[4:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // stop offering and let the pipeline run empty
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    offer_pixel(4'd0, 64'd0);
    offer_pixel(4'd15, '1);
    offer_pixel(4'd7, 64'(STROBE_GAP));
  endtask

  task automatic test_directed_modes();
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_OFF));
    write_reg(CFG_STROBE_ENABLE, 16'd1);
    offer_pixel(4'd0, 64'(STROBE_ON - 1));
    offer_pixel(4'd15, 64'(STROBE_ON));
    offer_pixel(4'd3, 64'(STROBE_GAP));
    offer_pixel(4'd4, 64'(STROBE_GAP + 1));
    offer_pixel(4'd9, 64'(STROBE_OFF));
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_SPARE_HI));
    offer_pixel(4'd5, 64'd10);
    // strobe stays on but commanded color ignores it
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_COMMANDED));
    write_reg(CFG_COMMANDED_RED, 16'd31);
    write_reg(CFG_COMMANDED_GREEN, 16'd63);
    write_reg(CFG_COMMANDED_BLUE, 16'd31);
    offer_pixel(4'd15, 64'd0);
    drain();
    write_reg(CFG_STROBE_ENABLE, 16'd0);
    write_reg(CFG_PATTERN_MODE, 16'(MODE_RED_GREEN));
    offer_pixel(4'd7, 64'd1);
    offer_pixel(4'd8, 64'd1);
    // offset of almost a full turn wraps around and moves every led by one unit
    drain();
    write_reg(CFG_ANGLE_OFFSET, 16'hFFFF);
    offer_pixel(4'd0, 64'd1);
    offer_pixel(4'd7, 64'd1);
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_RED));
    offer_pixel(4'd2, 64'd0);
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_GREEN));
    offer_pixel(4'd12, 64'd0);
    drain();
    write_reg(CFG_ANGLE_OFFSET, 16'd0);
    write_reg(CFG_PATTERN_MODE, 16'(MODE_POLICE));
    offer_pixel(4'd0, 64'd0);
    offer_pixel(4'd8, 64'd83333);
    offer_pixel(4'd8, 64'd83334);
    offer_pixel(4'd0, 64'(SECOND_US / 2));
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_POLICE_LEFT));
    offer_pixel(4'd0, 64'd0);
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_POLICE_RIGHT));
    offer_pixel(4'd8, 64'(SECOND_US / 2));
    // chase steps 16 to 19 light nothing
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_CHASE));
    offer_pixel(4'd15, 64'(16 * SECOND_US - 1));
    offer_pixel(4'd0, 64'(16 * SECOND_US));
    offer_pixel(4'd0, '1);
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_HEADING));
    offer_pixel(4'd3, 64'd0);
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_RAINBOW));
    offer_pixel(4'd15, 64'(SECOND_US - 1));
  endtask

  // wide write data keeps only the register width, spare indexes do nothing
  task automatic test_register_width();
    drain();
    write_reg(CFG_PATTERN_MODE, 16'hFFF0 | 16'(MODE_COMMANDED));
    write_reg(CFG_COMMANDED_RED, 16'hFFE5);
    write_reg(CFG_COMMANDED_GREEN, 16'hFFC9);
    write_reg(CFG_COMMANDED_BLUE, 16'hFFE2);
    write_reg(CFG_STROBE_ENABLE, 16'hFFFE);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    offer_pixel(4'd6, {$urandom, $urandom});
    offer_pixel(4'd11, {$urandom, $urandom});
  endtask

  task automatic test_random_settings();
    logic [LED_W-1:0]      led;
    logic [CFG_DATA_W-1:0] offset;
    logic [CFG_DATA_W-1:0] strobe;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p % 4)
        0: offset = 16'h0000;
        1: offset = 16'hFFFF;
        default: offset = 16'($urandom);
      endcase
      strobe = (p <= MODE_GREEN) ? 16'd1 : 16'($urandom_range(0, 1));
      write_reg(CFG_PATTERN_MODE, 16'(p));
      write_reg(CFG_STROBE_ENABLE, strobe);
      write_reg(CFG_ANGLE_OFFSET, offset);
      case (p % 3)
        0: begin
          write_reg(CFG_COMMANDED_RED, 16'd31);
          write_reg(CFG_COMMANDED_GREEN, 16'd63);
          write_reg(CFG_COMMANDED_BLUE, 16'd31);
        end
        1: begin
          write_reg(CFG_COMMANDED_RED, 16'd0);
          write_reg(CFG_COMMANDED_GREEN, 16'd0);
          write_reg(CFG_COMMANDED_BLUE, 16'd0);
        end
        default: begin
          write_reg(CFG_COMMANDED_RED, 16'($urandom_range(0, 31)));
          write_reg(CFG_COMMANDED_GREEN, 16'($urandom_range(0, 63)));
          write_reg(CFG_COMMANDED_BLUE, 16'($urandom_range(0, 31)));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        led = 4'($urandom_range(0, RING_SIZE - 1));
        offer_pixel(led, pick_time(led));
      end
    end
  endtask

  // the receiver holds off while items keep coming, so the input stalls
  task automatic test_output_stall();
    logic [LED_W-1:0] led;
    drain();
    write_reg(CFG_PATTERN_MODE, 16'(MODE_RAINBOW));
    write_reg(CFG_ANGLE_OFFSET, 16'($urandom));
    hold_requests++;
    burst_left = PRESSURE_ITEMS;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      led = 4'($urandom_range(0, RING_SIZE - 1));
      offer_pixel(led, pick_time(led));
    end
  endtask

  initial begin : receiver
    int hold_left;
    int style;
    int style_left;
    int tick;
    hold_left = 0;
    style = 0;
    style_left = 0;
    tick = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_LEN - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 5) == 0);
          default: out_ready_i <= (tick % 5 < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_colors
    color_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        $error("color result with nothing expected: %0d %0d %0d", red_o, green_o, blue_o);
        err_count++;
      end else begin
        want = expected_colors.pop_front();
        if (red_o !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, red_o);
          err_count++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, green_o);
          err_count++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, blue_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d colors outstanding", STALL_LIMIT,
               expected_colors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    led_position_i = '0;
    time_us_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    for (int i = 0; i < 1024; i++) begin
      sine_lut[i] = 8'($rtoi(12.5 * (1.0 + $sin(TWO_PI * i / 1024.0))));
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed_modes();
    test_register_width();
    test_random_settings();
    test_output_stall();
    drain();

    $display("%0d LED items and %0d colors checked over %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("all sixteen mode codes, strobe and police edges, a %0d-cycle output hold",
             HOLD_LEN);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lrpg_pkg.sv
rtl/core/lrpg_time_reduce.sv
rtl/core/lrpg_color.sv
rtl/core/led_ring_pattern_generator.sv
test/testbench.sv
